FILE: rtl/core/usg_pkg.sv
// Shared types, constants and arithmetic helpers for the UV sphere grid point generator.
// No dependencies; every other file in rtl/core refers to this package by scoped names.
package usg_pkg;

    localparam int CNT_W      = 9;
    localparam int RADIUS_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IDX_W      = 17;

    localparam int DEF_MAX_STACKS  = 256;
    localparam int DEF_MAX_SECTORS = 256;

    localparam logic [8:0]  RST_STACKS  = 9'd18;
    localparam logic [8:0]  RST_SECTORS = 9'd36;
    localparam logic [15:0] RST_RADIUS  = 16'd256;

    // Configuration register indexes
    localparam logic [1:0] CFG_STACKS  = 2'd0;
    localparam logic [1:0] CFG_SECTORS = 2'd1;
    localparam logic [1:0] CFG_RADIUS  = 2'd2;

    // Record kinds
    localparam logic KIND_VERTEX   = 1'b0;
    localparam logic KIND_TRIANGLE = 1'b1;

    // Fraction divider: quotient bits per stage and latency
    localparam int DIV_BITS      = 32;
    localparam int DIV_PER_STAGE = 4;
    localparam int DIV_STAGES    = DIV_BITS / DIV_PER_STAGE;
    localparam int DIV_LAT       = DIV_STAGES + 1;
    localparam int DIV_TEX_BITS  = 16;

    // Sine/cosine unit latency and the two rounding stages after it
    localparam int SC_LAT  = 13;
    localparam int MUL_LAT = 2;

    localparam logic [30:0] Q30_ONE = 31'h4000_0000;
    localparam logic [30:0] PIH_Q30 = 31'd1686629713;

    // Reciprocals for the constant divisions of the Horner steps
    localparam logic [31:0] RECIP_42 = 32'((64'd1 << 32) / 42);
    localparam logic [31:0] RECIP_20 = 32'((64'd1 << 32) / 20);
    localparam logic [31:0] RECIP_6  = 32'((64'd1 << 32) / 6);
    localparam logic [31:0] RECIP_56 = 32'((64'd1 << 32) / 56);
    localparam logic [31:0] RECIP_30 = 32'((64'd1 << 32) / 30);
    localparam logic [31:0] RECIP_12 = 32'((64'd1 << 32) / 12);

    typedef struct packed {
        logic signed [16:0] pos_x;
        logic signed [16:0] pos_y;
        logic signed [16:0] pos_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic [16:0]        tex_s;
        logic [16:0]        tex_t;
        logic [16:0]        k1;
        logic [16:0]        k2;
        logic               upper;
        logic               lower;
    } point_t;

    // Quotient estimate by reciprocal; may be one below the true quotient.
    function automatic logic [29:0] div_est(logic [29:0] v, logic [31:0] m);
        logic [61:0] p;
        p = 62'(v) * 62'(m);
        return 30'(p >> 32);
    endfunction

    // Corrects the estimate and returns one minus the quotient, in Q1.30.
    function automatic logic [30:0] one_minus_div(logic [29:0] v, logic [29:0] qe,
                                                  logic [5:0] d);
        logic [35:0] prod;
        logic [29:0] rem;
        logic [29:0] q;
        prod = 36'(qe) * 36'(d);
        rem  = 30'(36'(v) - prod);
        q    = (rem >= 30'(d)) ? qe + 30'd1 : qe;
        return Q30_ONE - 31'(q);
    endfunction

    // Truncating Q1.30 product.
    function automatic logic [30:0] mul_q30(logic [29:0] a, logic [30:0] b);
        logic [60:0] p;
        p = 61'(a) * 61'(b);
        return 31'(p >> 30);
    endfunction

    // Signed product rounded half away from zero, then shifted right by sh.
    function automatic logic signed [33:0] rnd_mul(logic signed [33:0] a,
                                                   logic signed [33:0] b, int sh);
        logic [32:0] ua;
        logic [32:0] ub;
        logic [65:0] p;
        logic [33:0] m;
        ua = a[33] ? 33'(-a) : 33'(a);
        ub = b[33] ? 33'(-b) : 33'(b);
        p  = 66'(ua) * 66'(ub);
        m  = 34'((p + (66'd1 << (sh - 1))) >> sh);
        return (a[33] != b[33]) ? -$signed(m) : $signed(m);
    endfunction

endpackage

FILE: rtl/core/uv_sphere_grid_point_generator_core.sv
// UV sphere grid point generator: each input item (row, column) produces a vertex item
// and up to two triangle items. A new point can enter every cycle while s_tready is high;
// the pipeline is 1 + DIV_LAT + 1 + SC_LAT + MUL_LAT = 26 stages deep, and the output sequencer
// registers the point before its first output item. The single output port sends one item
// per cycle while m_tready is high, so a point yields only its vertex item where it starts no
// cell (row st_eff or column se_eff), two items on rows 0 and st_eff-1 and three elsewhere; the
// output sequencer sets the sustained rate. Counts are clamped to [2, MAX_STACKS] and
// [3, MAX_SECTORS]. Depends on usg_pkg, usg_fdiv, usg_sincos and usg_emit.
module uv_sphere_grid_point_generator_core #(
    parameter int MAX_STACKS  = usg_pkg::DEF_MAX_STACKS,
    parameter int MAX_SECTORS = usg_pkg::DEF_MAX_SECTORS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // stack_row [8:0], sector_col [17:9]
    output logic         m_tvalid,
    input  logic         m_tready,
    // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_s, tex_t, corner_a, corner_b,
    // corner_c_and_last, from bit 0 up
    output logic [191:0] m_tdata,
    output logic         m_tuser,   // record_kind
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_wdata
);

    localparam int D2_LEN = usg_pkg::SC_LAT + usg_pkg::MUL_LAT;

    typedef struct packed {
        logic [16:0] tex_s;
        logic [16:0] tex_t;
        logic [16:0] k1;
        logic [16:0] k2;
        logic        upper;
        logic        lower;
    } meta_t;

    logic [8:0]  stacks_reg, sectors_reg;
    logic [15:0] radius_reg;
    logic [8:0]  st_eff, se_eff;
    logic        en, pt_ready;

    logic [8:0]  row_c_reg, col_c_reg;
    logic        vc_reg;
    logic [8:0]  d1_row_reg [usg_pkg::DIV_LAT];
    logic [8:0]  d1_col_reg [usg_pkg::DIV_LAT];
    logic        d1_v_reg   [usg_pkg::DIV_LAT];

    logic [32:0] qr, qc;
    logic [8:0]  r16r, r16c, r32c;

    logic [31:0] pe_a_reg, pa_a_reg;
    meta_t       meta_a_reg;
    logic        va_reg;
    meta_t       meta_next;
    logic [8:0]  row_a, col_a;
    logic [18:0] k1_w, k2_w;
    logic        starts_cell;

    meta_t       d2_meta_reg [D2_LEN];
    logic        d2_v_reg    [D2_LEN];

    logic signed [31:0] sin_e, cos_e, sin_a, cos_a;
    logic signed [33:0] xz_reg, py1_reg, nx1_reg, ny1_reg, nz1_reg, sa1_reg, ca1_reg;
    logic signed [33:0] px_reg, pz_reg, py2_reg, nx2_reg, ny2_reg, nz2_reg;
    usg_pkg::point_t    pt;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stacks_reg  <= usg_pkg::RST_STACKS;
            sectors_reg <= usg_pkg::RST_SECTORS;
            radius_reg  <= usg_pkg::RST_RADIUS;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                usg_pkg::CFG_STACKS:  stacks_reg  <= cfg_wdata[8:0];
                usg_pkg::CFG_SECTORS: sectors_reg <= cfg_wdata[8:0];
                usg_pkg::CFG_RADIUS:  radius_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        st_eff = stacks_reg;
        if (stacks_reg < 9'd2) begin
            st_eff = 9'd2;
        end else if (32'(stacks_reg) > MAX_STACKS) begin
            st_eff = 9'(MAX_STACKS);
        end
        se_eff = sectors_reg;
        if (sectors_reg < 9'd3) begin
            se_eff = 9'd3;
        end else if (32'(sectors_reg) > MAX_SECTORS) begin
            se_eff = 9'(MAX_SECTORS);
        end
    end

    // The whole pipeline advances together unless a finished point waits at the end.
    assign en       = !d2_v_reg[D2_LEN-1] || pt_ready;
    assign s_tready = en;

    // Clamp stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg <= 1'b0;
        end else if (en) begin
            vc_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            row_c_reg <= (s_tdata[8:0] > st_eff) ? st_eff : s_tdata[8:0];
            col_c_reg <= (s_tdata[17:9] > se_eff) ? se_eff : s_tdata[17:9];
        end
    end

    usg_fdiv u_div_row (
        .aclk  (aclk),
        .en    (en),
        .num   (row_c_reg),
        .den   (st_eff),
        .quot  (qr),
        .rem16 (r16r),
        .rem32 ()
    );

    usg_fdiv u_div_col (
        .aclk  (aclk),
        .en    (en),
        .num   (col_c_reg),
        .den   (se_eff),
        .quot  (qc),
        .rem16 (r16c),
        .rem32 (r32c)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < usg_pkg::DIV_LAT; i++) begin
                d1_v_reg[i] <= 1'b0;
            end
        end else if (en) begin
            d1_v_reg[0] <= vc_reg;
            for (int i = 1; i < usg_pkg::DIV_LAT; i++) begin
                d1_v_reg[i] <= d1_v_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d1_row_reg[0] <= row_c_reg;
            d1_col_reg[0] <= col_c_reg;
            for (int i = 1; i < usg_pkg::DIV_LAT; i++) begin
                d1_row_reg[i] <= d1_row_reg[i-1];
                d1_col_reg[i] <= d1_col_reg[i-1];
            end
        end
    end

    // Angle stage: rounding of the quotients, vertex indices and cell flags
    assign row_a       = d1_row_reg[usg_pkg::DIV_LAT-1];
    assign col_a       = d1_col_reg[usg_pkg::DIV_LAT-1];
    assign k1_w        = 19'(row_a) * 19'({1'b0, se_eff} + 10'd1) + 19'(col_a);
    assign k2_w        = k1_w + 19'(se_eff) + 19'd1;
    assign starts_cell = (row_a < st_eff) && (col_a < se_eff);

    always_comb begin
        meta_next.tex_s = qc[32:16] + 17'((10'(r16c) + 10'(se_eff >> 1)) >= 10'(se_eff));
        meta_next.tex_t = qr[32:16] + 17'((10'(r16r) + 10'(st_eff >> 1)) >= 10'(st_eff));
        meta_next.k1    = 17'(k1_w);
        meta_next.k2    = 17'(k2_w);
        meta_next.upper = starts_cell && (row_a != 9'd0);
        meta_next.lower = starts_cell && (row_a != st_eff - 9'd1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (en) begin
            va_reg <= d1_v_reg[usg_pkg::DIV_LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // Elevation is a quarter turn minus half the row fraction, rounded half up.
            pe_a_reg   <= 32'h4000_0000 - 32'((qr + 33'd1) >> 1);
            pa_a_reg   <= 32'(qc + 33'((10'(r32c) + 10'(se_eff >> 1)) >= 10'(se_eff)));
            meta_a_reg <= meta_next;
        end
    end

    usg_sincos u_sc_elev (
        .aclk    (aclk),
        .en      (en),
        .phase   (pe_a_reg),
        .sin_q30 (sin_e),
        .cos_q30 (cos_e)
    );

    usg_sincos u_sc_azim (
        .aclk    (aclk),
        .en      (en),
        .phase   (pa_a_reg),
        .sin_q30 (sin_a),
        .cos_q30 (cos_a)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < D2_LEN; i++) begin
                d2_v_reg[i] <= 1'b0;
            end
        end else if (en) begin
            d2_v_reg[0] <= va_reg;
            for (int i = 1; i < D2_LEN; i++) begin
                d2_v_reg[i] <= d2_v_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d2_meta_reg[0] <= meta_a_reg;
            for (int i = 1; i < D2_LEN; i++) begin
                d2_meta_reg[i] <= d2_meta_reg[i-1];
            end
        end
    end

    // Two rounding stages: the horizontal radius first, then the x and z positions.
    always_ff @(posedge aclk) begin
        if (en) begin
            xz_reg  <= usg_pkg::rnd_mul(34'(radius_reg), 34'(cos_e), 14);
            py1_reg <= usg_pkg::rnd_mul(34'(radius_reg), 34'(sin_e), 30);
            nx1_reg <= usg_pkg::rnd_mul(34'(cos_e), 34'(sin_a), 46);
            ny1_reg <= usg_pkg::rnd_mul(34'(sin_e), 34'sd1, 16);
            nz1_reg <= usg_pkg::rnd_mul(34'(cos_e), 34'(cos_a), 46);
            sa1_reg <= 34'(sin_a);
            ca1_reg <= 34'(cos_a);

            px_reg  <= usg_pkg::rnd_mul(xz_reg, sa1_reg, 46);
            pz_reg  <= usg_pkg::rnd_mul(xz_reg, ca1_reg, 46);
            py2_reg <= py1_reg;
            nx2_reg <= nx1_reg;
            ny2_reg <= ny1_reg;
            nz2_reg <= nz1_reg;
        end
    end

    always_comb begin
        pt.pos_x  = 17'(px_reg);
        pt.pos_y  = 17'(py2_reg);
        pt.pos_z  = 17'(pz_reg);
        pt.norm_x = 16'(nx2_reg);
        pt.norm_y = 16'(ny2_reg);
        pt.norm_z = 16'(nz2_reg);
        pt.tex_s  = d2_meta_reg[D2_LEN-1].tex_s;
        pt.tex_t  = d2_meta_reg[D2_LEN-1].tex_t;
        pt.k1     = d2_meta_reg[D2_LEN-1].k1;
        pt.k2     = d2_meta_reg[D2_LEN-1].k2;
        pt.upper  = d2_meta_reg[D2_LEN-1].upper;
        pt.lower  = d2_meta_reg[D2_LEN-1].lower;
    end

    usg_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .pt_valid (d2_v_reg[D2_LEN-1]),
        .pt       (pt),
        .pt_ready (pt_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

FILE: rtl/core/usg_fdiv.sv
// Pipelined restoring divider giving index/count as a 32-bit binary fraction.
// Depends on usg_pkg for the stage split; the numerator never exceeds the divisor.
module usg_fdiv (
    input  logic        aclk,
    input  logic        en,
    input  logic [8:0]  num,
    input  logic [8:0]  den,
    output logic [32:0] quot,
    output logic [8:0]  rem16,
    output logic [8:0]  rem32
);

    typedef struct packed {
        logic [32:0] q;
        logic [8:0]  r;
        logic [8:0]  r16;
    } div_st_t;

    div_st_t stg_reg  [usg_pkg::DIV_STAGES+1];
    div_st_t stg_next [usg_pkg::DIV_STAGES+1];

    // The integer bit is set only when index equals count.
    always_comb begin
        stg_next[0].q   = 33'(num == den);
        stg_next[0].r   = (num == den) ? 9'd0 : num;
        stg_next[0].r16 = 9'd0;
    end

    for (genvar s = 1; s <= usg_pkg::DIV_STAGES; s++) begin : g_stage
        always_comb begin
            div_st_t    w;
            logic [9:0] r2;
            w = stg_reg[s-1];
            for (int j = 0; j < usg_pkg::DIV_PER_STAGE; j++) begin
                r2 = {w.r, 1'b0};
                if (r2 >= {1'b0, den}) begin
                    w.r = 9'(r2 - {1'b0, den});
                    w.q = {w.q[31:0], 1'b1};
                end else begin
                    w.r = 9'(r2);
                    w.q = {w.q[31:0], 1'b0};
                end
                if ((s - 1) * usg_pkg::DIV_PER_STAGE + j + 1 == usg_pkg::DIV_TEX_BITS) begin
                    w.r16 = w.r;
                end
            end
            stg_next[s] = w;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s <= usg_pkg::DIV_STAGES; s++) begin
                stg_reg[s] <= stg_next[s];
            end
        end
    end

    assign quot  = stg_reg[usg_pkg::DIV_STAGES].q;
    assign rem16 = stg_reg[usg_pkg::DIV_STAGES].r16;
    assign rem32 = stg_reg[usg_pkg::DIV_STAGES].r;

endmodule

FILE: rtl/core/usg_sincos.sv
// Pipelined sine and cosine of a 32-bit turn fraction, Q2.30 results.
// Depends on usg_pkg for the Horner helpers.
module usg_sincos (
    input  logic               aclk,
    input  logic               en,
    input  logic [31:0]        phase,
    output logic signed [31:0] sin_q30,
    output logic signed [31:0] cos_q30
);

    typedef struct packed {
        logic [1:0]  qd;
        logic        fold;
        logic [29:0] x;
        logic [29:0] x2;
    } carry_t;

    carry_t      cr_reg [12];
    logic [29:0] g_reg;
    logic [29:0] es3_reg, ec3_reg, es6_reg, ec6_reg, es9_reg, ec9_reg;
    logic [29:0] ps5_reg, pc5_reg, ps8_reg, pc8_reg;
    logic [29:0] pds6_reg, pdc6_reg, pds9_reg, pdc9_reg;
    logic [30:0] ts4_reg, tc4_reg, ts7_reg, tc7_reg, ts10_reg, tc10_reg;
    logic [30:0] sin11_reg, cos11_reg;
    logic signed [31:0] sn12_reg, cs12_reg;
    logic signed [31:0] s_sel, c_sel;
    logic [30:0] cos_prod;

    assign cos_prod = usg_pkg::mul_q30(cr_reg[10].x2, tc10_reg);

    // Undo the fold first, then rotate by quadrant.
    always_comb begin
        if (cr_reg[11].fold) begin
            s_sel = 32'(cos11_reg);
            c_sel = 32'(sin11_reg);
        end else begin
            s_sel = 32'(sin11_reg);
            c_sel = 32'(cos11_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cr_reg[0].qd   <= phase[31:30];
            cr_reg[0].fold <= phase[29];
            cr_reg[0].x    <= 30'd0;
            cr_reg[0].x2   <= 30'd0;
            g_reg <= phase[29] ? 30'(usg_pkg::Q30_ONE - 31'(phase[29:0])) : phase[29:0];

            cr_reg[1].qd   <= cr_reg[0].qd;
            cr_reg[1].fold <= cr_reg[0].fold;
            cr_reg[1].x    <= 30'(usg_pkg::mul_q30(g_reg, usg_pkg::PIH_Q30));
            cr_reg[1].x2   <= cr_reg[0].x2;
            cr_reg[2].qd   <= cr_reg[1].qd;
            cr_reg[2].fold <= cr_reg[1].fold;
            cr_reg[2].x    <= cr_reg[1].x;
            cr_reg[2].x2   <= 30'(usg_pkg::mul_q30(cr_reg[1].x, 31'(cr_reg[1].x)));
            for (int k = 3; k < 12; k++) begin
                cr_reg[k] <= cr_reg[k-1];
            end

            es3_reg  <= usg_pkg::div_est(cr_reg[2].x2, usg_pkg::RECIP_42);
            ec3_reg  <= usg_pkg::div_est(cr_reg[2].x2, usg_pkg::RECIP_56);
            ts4_reg  <= usg_pkg::one_minus_div(cr_reg[3].x2, es3_reg, 6'd42);
            tc4_reg  <= usg_pkg::one_minus_div(cr_reg[3].x2, ec3_reg, 6'd56);
            ps5_reg  <= 30'(usg_pkg::mul_q30(cr_reg[4].x2, ts4_reg));
            pc5_reg  <= 30'(usg_pkg::mul_q30(cr_reg[4].x2, tc4_reg));
            es6_reg  <= usg_pkg::div_est(ps5_reg, usg_pkg::RECIP_20);
            ec6_reg  <= usg_pkg::div_est(pc5_reg, usg_pkg::RECIP_30);
            pds6_reg <= ps5_reg;
            pdc6_reg <= pc5_reg;
            ts7_reg  <= usg_pkg::one_minus_div(pds6_reg, es6_reg, 6'd20);
            tc7_reg  <= usg_pkg::one_minus_div(pdc6_reg, ec6_reg, 6'd30);
            ps8_reg  <= 30'(usg_pkg::mul_q30(cr_reg[7].x2, ts7_reg));
            pc8_reg  <= 30'(usg_pkg::mul_q30(cr_reg[7].x2, tc7_reg));
            es9_reg  <= usg_pkg::div_est(ps8_reg, usg_pkg::RECIP_6);
            ec9_reg  <= usg_pkg::div_est(pc8_reg, usg_pkg::RECIP_12);
            pds9_reg <= ps8_reg;
            pdc9_reg <= pc8_reg;
            ts10_reg <= usg_pkg::one_minus_div(pds9_reg, es9_reg, 6'd6);
            tc10_reg <= usg_pkg::one_minus_div(pdc9_reg, ec9_reg, 6'd12);
            sin11_reg <= usg_pkg::mul_q30(cr_reg[10].x, ts10_reg);
            cos11_reg <= usg_pkg::Q30_ONE - (cos_prod >> 1);

            case (cr_reg[11].qd)
                2'd0: begin sn12_reg <= s_sel;  cs12_reg <= c_sel;  end
                2'd1: begin sn12_reg <= c_sel;  cs12_reg <= -s_sel; end
                2'd2: begin sn12_reg <= -s_sel; cs12_reg <= -c_sel; end
                default: begin sn12_reg <= -c_sel; cs12_reg <= s_sel; end
            endcase
        end
    end

    assign sin_q30 = sn12_reg;
    assign cos_q30 = cs12_reg;

endmodule

FILE: rtl/core/usg_emit.sv
// Output sequencer: turns one finished grid point into its vertex and triangle items.
// Depends on usg_pkg for point_t and the record kinds.
module usg_emit (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  pt_valid,
    input  usg_pkg::point_t       pt,
    output logic                  pt_ready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [191:0]          m_tdata,
    output logic                  m_tuser
);

    typedef enum logic [1:0] {ST_IDLE, ST_VTX, ST_UPPER, ST_LOWER} state_t;

    state_t          state_reg;
    state_t          state_next;
    usg_pkg::point_t pt_reg;
    logic            rec_last;
    logic [16:0]     ca, cb, cc_idx;

    always_comb begin
        unique case (state_reg)
            ST_IDLE:  state_next = ST_IDLE;
            ST_VTX:   state_next = pt_reg.upper ? ST_UPPER : (pt_reg.lower ? ST_LOWER : ST_IDLE);
            ST_UPPER: state_next = pt_reg.lower ? ST_LOWER : ST_IDLE;
            ST_LOWER: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    assign rec_last = (state_reg != ST_IDLE) && (state_next == ST_IDLE);
    assign pt_ready = (state_reg == ST_IDLE) || (m_tready && rec_last);
    assign m_tvalid = (state_reg != ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            if (pt_valid && pt_ready) begin
                state_reg <= ST_VTX;
                pt_reg    <= pt;
            end else if (m_tvalid && m_tready) begin
                state_reg <= state_next;
            end
        end
    end

    always_comb begin
        ca     = 17'd0;
        cb     = 17'd0;
        cc_idx = 17'd0;
        if (state_reg == ST_UPPER) begin
            ca     = pt_reg.k1;
            cb     = pt_reg.k2;
            cc_idx = pt_reg.k1 + 17'd1;
        end else if (state_reg == ST_LOWER) begin
            ca     = pt_reg.k1 + 17'd1;
            cb     = pt_reg.k2;
            cc_idx = pt_reg.k2 + 17'd1;
        end
    end

    always_comb begin
        if (state_reg == ST_UPPER || state_reg == ST_LOWER) begin
            m_tuser = usg_pkg::KIND_TRIANGLE;
            m_tdata = {7'd0, cc_idx, rec_last, cb, ca, 133'd0};
        end else begin
            m_tuser = usg_pkg::KIND_VERTEX;
            m_tdata = {7'd0, 17'd0, rec_last, 17'd0, 17'd0, pt_reg.tex_t, pt_reg.tex_s,
                       pt_reg.norm_z, pt_reg.norm_y, pt_reg.norm_x,
                       pt_reg.pos_z, pt_reg.pos_y, pt_reg.pos_x};
        end
    end

    a_upper_only_when_flagged: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPPER) |-> pt_reg.upper)
        else $error("upper triangle item emitted for a point without one");

    a_ready_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        pt_ready |-> ((state_reg == ST_IDLE) || (m_tready && rec_last)))
        else $error("new point taken while earlier items still pending");

    a_load_starts_vertex: assert property (@(posedge aclk) disable iff (!aresetn)
        (pt_valid && pt_ready) |=> (state_reg == ST_VTX))
        else $error("a loaded point did not start with its vertex item");

endmodule
